>>> hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define CHK_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// Next-cycle implication, disabled while reset is low
`define CHK_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

>>> hdl/fth_pkg.sv
// ---------------------------------------------------------------------------
// fth_pkg
// Types and codes shared by the flow table and its checker.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package fth_pkg;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;
    localparam logic [31:0] TTL_RESET = 32'd60;

    localparam logic [1:0] OP_UPSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_SWEEP  = 2'd2;

    localparam logic [2:0] ST_FOUND    = 3'd0;
    localparam logic [2:0] ST_INSERTED = 3'd1;
    localparam logic [2:0] ST_MISS     = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_SWEPT    = 3'd4;

    // One table slot as stored in the memory
    typedef struct packed {
        logic        valid;
        logic [55:0] key;
        logic [47:0] peer;
        logic [16:0] handle_tcp;
        logic [31:0] stamp;
    } slot_t;

endpackage

>>> hdl/flow_table_hash_probe_ttl_unit.sv
// ---------------------------------------------------------------------------
// flow_table_hash_probe_ttl_unit
// Session table with an FNV-1a-style home slot, bounded linear probing and aging.
// ---------------------------------------------------------------------------
// One item is handled at a time. Upsert and lookup first hash the key in three
// rounds (H1, H2, H3), one 32x32 multiply per cycle, then read (RD) and
// evaluate (EV) each probed slot of the single-port table memory, at most
// PROBE_LIMIT probes. The result is handed off in FIN once the output register
// is free, and the next word is taken in IDLE. A sweep reads and evaluates
// every slot, or goes straight to FIN when the table is empty. After reset the
// block clears the valid bit of every slot, one slot per cycle, and takes no
// word until every slot is cleared; configuration writes are taken at any time.
`timescale 1ns / 1ps

module flow_table_hash_probe_ttl_unit #(
    parameter int TABLE_DEPTH = 1024,
    parameter int PROBE_LIMIT = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [31:0] s_current_time,
    input  logic [31:0] s_flow_ip,
    input  logic [15:0] s_flow_port,
    input  logic [7:0]  s_flow_proto,
    input  logic [15:0] s_handle,
    input  logic        s_peer_present,
    input  logic [31:0] s_peer_ip,
    input  logic [15:0] s_peer_port,
    input  logic        s_tcp_flag,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [9:0]  m_slot_index,
    output logic [15:0] m_out_handle,
    output logic [31:0] m_out_peer_ip,
    output logic [15:0] m_out_peer_port,
    output logic        m_out_tcp,
    output logic [10:0] m_expired_count,
    output logic [10:0] m_live_count
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int PW = $clog2(PROBE_LIMIT + 1);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_DEPTH - 1);
    localparam logic [PW-1:0] LAST_PROBE = PW'(PROBE_LIMIT - 1);

    typedef enum logic [9:0] {
        S_CLEAR = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_H1    = 10'b0000000100,
        S_H2    = 10'b0000001000,
        S_H3    = 10'b0000010000,
        S_RD    = 10'b0000100000,
        S_EV    = 10'b0001000000,
        S_SW_RD = 10'b0010000000,
        S_SW_EV = 10'b0100000000,
        S_FIN   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    // table memory and its read port
    fth_pkg::slot_t mem [TABLE_DEPTH];
    fth_pkg::slot_t rd_word_reg;
    fth_pkg::slot_t wr_word;
    logic           wr_en;

    logic [31:0]   ttl_reg;
    logic [1:0]    op_reg;
    logic [31:0]   now_reg;
    logic [55:0]   key_reg;
    logic [15:0]   hnd_reg;
    logic          has_peer_reg;
    logic [47:0]   peer_reg;
    logic          tcp_reg;
    logic [31:0]   hash_reg;
    logic [AW-1:0] addr_reg;
    logic [PW-1:0] probe_reg;
    logic [CW-1:0] active_reg;
    logic [CW-1:0] gone_reg;

    logic [2:0]    res_status_reg;
    logic [AW-1:0] res_slot_reg;
    logic [15:0]   res_hnd_reg;
    logic [47:0]   res_peer_reg;
    logic          res_tcp_reg;
    logic [CW-1:0] res_exp_reg;

    logic          m_valid_reg;
    logic [2:0]    m_status_reg;
    logic [9:0]    m_slot_reg;
    logic [15:0]   m_hnd_reg;
    logic [47:0]   m_peer_reg;
    logic          m_tcp_reg;
    logic [10:0]   m_exp_reg;
    logic [10:0]   m_live_reg;

    logic          stale;
    logic          match;
    logic [31:0]   mult_in;
    logic [31:0]   mult_out;
    logic          load_out;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign load_out  = (state_reg == S_FIN) && (!m_valid_reg || m_ready);

    // age test and key compare on the word just read
    assign stale = (now_reg - rd_word_reg.stamp) > ttl_reg;
    assign match = rd_word_reg.valid && (rd_word_reg.key == key_reg);

    // one hash round per cycle: xor a key word, then multiply
    always_comb begin
        mult_in = hash_reg;
        case (state_reg)
            S_H1:    mult_in = fth_pkg::FNV_BASIS ^ key_reg[55:24];
            S_H2:    mult_in = hash_reg ^ {16'd0, key_reg[23:8]};
            S_H3:    mult_in = hash_reg ^ {24'd0, key_reg[7:0]};
            default: mult_in = hash_reg;
        endcase
    end
    assign mult_out = mult_in * fth_pkg::FNV_PRIME;

    // write port: clear, upsert, retire
    always_comb begin
        wr_en   = 1'b0;
        wr_word = rd_word_reg;
        unique case (state_reg)
            S_CLEAR: begin
                wr_en         = 1'b1;
                wr_word.valid = 1'b0;
            end
            S_EV: begin
                if (op_reg == fth_pkg::OP_UPSERT) begin
                    if (match || !rd_word_reg.valid || stale) begin
                        wr_en              = 1'b1;
                        wr_word.valid      = 1'b1;
                        wr_word.key        = key_reg;
                        wr_word.handle_tcp = {hnd_reg, tcp_reg};
                        wr_word.stamp      = now_reg;
                        if (has_peer_reg) begin
                            wr_word.peer = peer_reg;
                        end else if (!match) begin
                            wr_word.peer = 48'd0;
                        end
                    end
                end else if (match && stale) begin
                    wr_en         = 1'b1;
                    wr_word.valid = 1'b0;
                end
            end
            S_SW_EV: begin
                if (rd_word_reg.valid && stale) begin
                    wr_en         = 1'b1;
                    wr_word.valid = 1'b0;
                end
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr_reg] <= wr_word;
        end
        if (state_reg == S_RD || state_reg == S_SW_RD) begin
            rd_word_reg <= mem[addr_reg];
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: if (addr_reg == LAST_SLOT) state_next = S_IDLE;
            S_IDLE: begin
                if (s_valid) begin
                    if (s_operation == fth_pkg::OP_UPSERT
                            || s_operation == fth_pkg::OP_LOOKUP) begin
                        state_next = S_H1;
                    end else if (s_operation == fth_pkg::OP_SWEEP) begin
                        state_next = (active_reg == '0) ? S_FIN : S_SW_RD;
                    end else begin
                        state_next = S_FIN;
                    end
                end
            end
            S_H1: state_next = S_H2;
            S_H2: state_next = S_H3;
            S_H3: state_next = S_RD;
            S_RD: state_next = S_EV;
            S_EV: begin
                if (op_reg == fth_pkg::OP_UPSERT) begin
                    if (match || !rd_word_reg.valid || stale || probe_reg == LAST_PROBE) begin
                        state_next = S_FIN;
                    end else begin
                        state_next = S_RD;
                    end
                end else if (!rd_word_reg.valid || match || probe_reg == LAST_PROBE) begin
                    state_next = S_FIN;
                end else begin
                    state_next = S_RD;
                end
            end
            S_SW_RD: state_next = S_SW_EV;
            S_SW_EV: state_next = (addr_reg == LAST_SLOT) ? S_FIN : S_SW_RD;
            S_FIN:   if (!m_valid_reg || m_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_CLEAR;
            addr_reg   <= '0;
            active_reg <= '0;
            ttl_reg    <= fth_pkg::TTL_RESET;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                ttl_reg <= cfg_data;
            end
            unique case (state_reg)
                S_CLEAR: addr_reg <= addr_reg + 1'b1;
                S_IDLE:  addr_reg <= '0;
                S_H3:    addr_reg <= mult_out[AW-1:0];
                S_EV: begin
                    if (op_reg == fth_pkg::OP_UPSERT) begin
                        if (!match && !rd_word_reg.valid) begin
                            active_reg <= active_reg + 1'b1;
                        end
                    end else if (match && stale && active_reg != '0) begin
                        active_reg <= active_reg - 1'b1;
                    end
                    addr_reg <= addr_reg + 1'b1;
                end
                S_SW_EV: begin
                    addr_reg <= addr_reg + 1'b1;
                    if (addr_reg == LAST_SLOT) begin
                        active_reg <= (gone_reg + CW'(rd_word_reg.valid && stale) > active_reg)
                                      ? '0
                                      : active_reg - gone_reg
                                        - CW'(rd_word_reg.valid && stale);
                    end
                end
                default: addr_reg <= addr_reg;
            endcase
        end
    end

    // item payload, hash and per-item result
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                op_reg         <= s_operation;
                now_reg        <= s_current_time;
                key_reg        <= {s_flow_ip, s_flow_port, s_flow_proto};
                hnd_reg        <= s_handle;
                has_peer_reg   <= s_peer_present;
                peer_reg       <= {s_peer_ip, s_peer_port};
                tcp_reg        <= s_tcp_flag;
                probe_reg      <= '0;
                gone_reg       <= '0;
                res_status_reg <= (s_operation == fth_pkg::OP_SWEEP)
                                  ? fth_pkg::ST_SWEPT : fth_pkg::ST_MISS;
                res_slot_reg   <= '0;
                res_hnd_reg    <= '0;
                res_peer_reg   <= '0;
                res_tcp_reg    <= 1'b0;
                res_exp_reg    <= '0;
            end
            S_H1, S_H2: hash_reg <= mult_out;
            S_EV: begin
                probe_reg <= probe_reg + 1'b1;
                if (op_reg == fth_pkg::OP_UPSERT) begin
                    if (match || !rd_word_reg.valid || stale) begin
                        res_status_reg <= match ? fth_pkg::ST_FOUND : fth_pkg::ST_INSERTED;
                        res_slot_reg   <= addr_reg;
                        res_hnd_reg    <= hnd_reg;
                        res_tcp_reg    <= tcp_reg;
                        res_peer_reg   <= wr_word.peer;
                    end else if (probe_reg == LAST_PROBE) begin
                        res_status_reg <= fth_pkg::ST_FULL;
                    end
                end else if (match && !stale) begin
                    res_status_reg <= fth_pkg::ST_FOUND;
                    res_slot_reg   <= addr_reg;
                    res_hnd_reg    <= rd_word_reg.handle_tcp[16:1];
                    res_tcp_reg    <= rd_word_reg.handle_tcp[0];
                    res_peer_reg   <= rd_word_reg.peer;
                end
            end
            S_SW_EV: begin
                if (rd_word_reg.valid && stale) begin
                    gone_reg <= gone_reg + 1'b1;
                end
                if (addr_reg == LAST_SLOT) begin
                    res_exp_reg <= gone_reg + CW'(rd_word_reg.valid && stale);
                end
            end
            default: hash_reg <= hash_reg;
        endcase
    end

    // output register: hold until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_status_reg <= res_status_reg;
            m_slot_reg   <= 10'(res_slot_reg);
            m_hnd_reg    <= res_hnd_reg;
            m_peer_reg   <= res_peer_reg;
            m_tcp_reg    <= res_tcp_reg;
            m_exp_reg    <= 11'(res_exp_reg);
            m_live_reg   <= 11'(active_reg);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_slot_index    = m_slot_reg;
    assign m_out_handle    = m_hnd_reg;
    assign m_out_peer_ip   = m_peer_reg[47:16];
    assign m_out_peer_port = m_peer_reg[15:0];
    assign m_out_tcp       = m_tcp_reg;
    assign m_expired_count = m_exp_reg;
    assign m_live_count    = m_live_reg;

endmodule

>>> hdl/fth_checker.sv
// ---------------------------------------------------------------------------
// fth_checker
// Port-level checks on the flow table's result channel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fth_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_status,
    input logic [10:0] m_expired_count,
    input logic [10:0] m_live_count
);

    // hold a stalled word
    `CHK_NEXT(a_hold_valid, aclk, aresetn, m_valid && !m_ready, m_valid)
    `CHK_NEXT(a_hold_status, aclk, aresetn, m_valid && !m_ready, $stable(m_status))

    // only defined status codes leave the block
    `CHK_IMPLY(a_status_code, aclk, aresetn, m_valid, m_status <= fth_pkg::ST_SWEPT)

    // a hit or insert leaves at least one live entry
    `CHK_IMPLY(a_live_on_hit, aclk, aresetn, m_valid && (m_status == fth_pkg::ST_FOUND || m_status == fth_pkg::ST_INSERTED), m_live_count != 11'd0)

    // only a sweep reports an expired count
    `CHK_IMPLY(a_exp_sweep_only, aclk, aresetn, m_valid && m_status != fth_pkg::ST_SWEPT, m_expired_count == 11'd0)

endmodule

bind flow_table_hash_probe_ttl_unit fth_checker u_fth_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_status        (m_status),
    .m_expired_count (m_expired_count),
    .m_live_count    (m_live_count)
);
